### rtl/dual_touch_virtual_joystick_unit_macros.svh
// ----------------------------------------------------------------------------
// Dual touch virtual joystick - assertion macros
// Shared concurrent assertion forms for the RTL modules.
// ----------------------------------------------------------------------------
`ifndef DUAL_TOUCH_VIRTUAL_JOYSTICK_UNIT_MACROS_SVH
`define DUAL_TOUCH_VIRTUAL_JOYSTICK_UNIT_MACROS_SVH

// checked outside reset only
`define DTVJ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define DTVJ_ASSERT_ALW(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/dtvj_pkg.sv
// ----------------------------------------------------------------------------
// dtvj_pkg
// Types, codes and constants of the dual touch virtual joystick.
// ----------------------------------------------------------------------------
package dtvj_pkg;

  localparam int unsigned COORD_BITS_DEF     = 12;
  localparam int unsigned AXIS_FRAC_BITS_DEF = 15;

  localparam int unsigned CFG_W   = 12;
  localparam int unsigned TOUCH_W = 12;
  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned KNOB_W  = 14;
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned APB_DW  = 32;

  localparam logic [CFG_W-1:0] CENTER_X_RST = 12'd540;
  localparam logic [CFG_W-1:0] RADIUS_RST   = 12'd400;
  localparam logic             PAD_EN_RST   = 1'b1;

  typedef enum logic [1:0] {
    FUNC_POINT   = 2'd0,
    FUNC_EMPTY   = 2'd1,
    FUNC_RELEASE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    REG_CENTER_X   = 2'd0,
    REG_RADIUS_X   = 2'd1,
    REG_RADIUS_Y   = 2'd2,
    REG_PAD_ENABLE = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic left_valid;
    logic right_valid;
  } pad_flags_t;

endpackage

### rtl/dtvj_serdiv.sv
// ----------------------------------------------------------------------------
// dtvj_serdiv
// Bit-serial restoring divider: one quotient bit per cycle, F+1 bits for a
// dividend no larger than the divisor, scaled by 2^F.
// ----------------------------------------------------------------------------
`include "dual_touch_virtual_joystick_unit_macros.svh"

module dtvj_serdiv import dtvj_pkg::*; #(
  parameter int unsigned W = CFG_W,
  parameter int unsigned F = AXIS_FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [F:0]   quot_o
);

  localparam int unsigned CW = $clog2(F + 1);
  localparam logic [CW-1:0] LastCnt = CW'(F);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W:0]    rem_q;
  logic [W-1:0]  dvs_q;
  logic [F:0]    quot_q;

  logic [W:0]    diff;
  logic          ge;
  logic [W:0]    rem_d;

  assign diff  = rem_q - {1'b0, dvs_q};
  assign ge    = (rem_q >= {1'b0, dvs_q});
  assign rem_d = ge ? diff : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= {1'b0, dividend_i};
        dvs_q  <= divisor_i;
        quot_q <= '0;
        cnt_q  <= LastCnt;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q  <= {rem_d[W-1:0], 1'b0};
        quot_q <= {quot_q[F-1:0], ge};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CW'(1);
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

  `DTVJ_ASSERT(a_start_when_free, clk_i, rst_ni, start_i |-> !busy_q, "divider restarted while busy")
  `DTVJ_ASSERT_ALW(a_busy_done_excl, clk_i, !(busy_q && done_q), "divider busy and done together")

endmodule

### rtl/dtvj_pad_tracker.sv
// ----------------------------------------------------------------------------
// dtvj_pad_tracker
// Per-pad touch state: valid and seen flags, anchor and current points.
// ----------------------------------------------------------------------------
`include "dual_touch_virtual_joystick_unit_macros.svh"

module dtvj_pad_tracker import dtvj_pkg::*; #(
  parameter int unsigned C = COORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  logic [1:0]         func_i,
  input  logic [TOUCH_W-1:0] touch_x_i,
  input  logic [TOUCH_W-1:0] touch_y_i,
  input  logic               last_i,
  input  logic [CFG_W-1:0]   center_x_i,
  input  logic               pad_enable_i,
  output pad_flags_t         flags_o,
  output logic [C-1:0]       anchor_o  [2][2],
  output logic [C-1:0]       current_o [2][2]
);

  localparam int unsigned CmpW = (C > CFG_W) ? C : CFG_W;

  logic [1:0]   valid_q, valid_d, seen_q, seen_d;
  logic [C-1:0] anchor_q  [2][2];
  logic [C-1:0] anchor_d  [2][2];
  logic [C-1:0] current_q [2][2];
  logic [C-1:0] current_d [2][2];
  logic [C-1:0] pt [2];
  logic         side;

  always_comb begin
    pt[0]     = C'(touch_x_i);
    pt[1]     = C'(touch_y_i);
    side      = (CmpW'(pt[0]) < CmpW'(center_x_i)) ? 1'b0 : 1'b1;
    valid_d   = valid_q;
    seen_d    = seen_q;
    anchor_d  = anchor_q;
    current_d = current_q;
    if (take_i) begin
      case (func_e'(func_i))
        FUNC_POINT: begin
          if (!seen_q[side]) begin
            seen_d[side] = 1'b1;
            if (!valid_q[side]) begin
              if (pad_enable_i) begin
                anchor_d[side]  = pt;
                current_d[side] = pt;
                valid_d[side]   = 1'b1;
              end
            end else begin
              current_d[side] = pt;
            end
          end
          if (last_i) begin
            valid_d = valid_d & seen_d;
            seen_d  = '0;
          end
        end
        FUNC_EMPTY: begin
          valid_d = valid_q & seen_q;
          seen_d  = '0;
        end
        FUNC_RELEASE: begin
          valid_d = '0;
          seen_d  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      seen_q  <= '0;
      for (int p = 0; p < 2; p++) begin
        for (int a = 0; a < 2; a++) begin
          anchor_q[p][a]  <= '0;
          current_q[p][a] <= '0;
        end
      end
    end else begin
      valid_q   <= valid_d;
      seen_q    <= seen_d;
      anchor_q  <= anchor_d;
      current_q <= current_d;
    end
  end

  assign flags_o.left_valid  = valid_q[0];
  assign flags_o.right_valid = valid_q[1];
  assign anchor_o            = anchor_q;
  assign current_o           = current_q;

  `DTVJ_ASSERT(a_release_clears, clk_i, rst_ni, (take_i && func_i == FUNC_RELEASE) |=> (valid_q == 2'b00 && seen_q == 2'b00), "release left a pad active")

endmodule

### rtl/dual_touch_virtual_joystick_unit.sv
// ----------------------------------------------------------------------------
// dual_touch_virtual_joystick_unit
// Two-pad touchscreen virtual joystick with Q1.15 stick outputs.
// ----------------------------------------------------------------------------
// Input words (func, touch_x, touch_y, last_in_event) arrive on a valid/ready
// channel; each accepted word yields exactly one result word on a valid/ready
// output channel. Pad state updates at the accepting edge, then the four
// axes are formed one after another in a single bit-serial divider, one
// quotient bit per cycle. Each axis passes S_LOAD and S_DIV; after the last
// one, S_DONE loads the result into the output register and the unit returns
// to S_IDLE, where the next word is taken, so no new word is accepted while
// one is in progress. in_ready is high whenever the unit is idle, also while
// a finished result still waits in the output register.
// If the receiver stalls, the result holds in the output register and a
// following word completes only once that register has been emptied.
// Configuration (centre line, radii, pad enable) is to be written over the
// APB port only while the unit is idle (the block leaves this to the user);
// pready is tied high. Reset clears both pads, the handshake and the output
// register, and loads the registers with centre 540, radii 400, pads enabled.
// ----------------------------------------------------------------------------
`include "dual_touch_virtual_joystick_unit_macros.svh"

module dual_touch_virtual_joystick_unit import dtvj_pkg::*; #(
  parameter int unsigned COORD_BITS     = COORD_BITS_DEF,
  parameter int unsigned AXIS_FRAC_BITS = AXIS_FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               func_i,
  input  logic [TOUCH_W-1:0]       touch_x_i,
  input  logic [TOUCH_W-1:0]       touch_y_i,
  input  logic                     last_in_event_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [AXIS_W-1:0] left_axis_x_o,
  output logic signed [AXIS_W-1:0] left_axis_y_o,
  output logic signed [AXIS_W-1:0] right_axis_x_o,
  output logic signed [AXIS_W-1:0] right_axis_y_o,
  output logic                     left_active_o,
  output logic                     right_active_o,
  output logic signed [KNOB_W-1:0] knob_x_o,
  output logic signed [KNOB_W-1:0] knob_y_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned F  = AXIS_FRAC_BITS;
  localparam int unsigned DW = (C > CFG_W) ? C : CFG_W;
  localparam int unsigned SW = (DW + 2 > KNOB_W) ? DW + 2 : KNOB_W;
  localparam logic [AXIS_W-1:0] AxisMax = {1'b0, {(AXIS_W-1){1'b1}}};

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  // configuration
  logic [CFG_W-1:0] center_x_q, radius_x_q, radius_y_q;
  logic             pad_en_q;
  logic             cfg_we;
  reg_idx_e         reg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= CENTER_X_RST;
      radius_x_q <= RADIUS_RST;
      radius_y_q <= RADIUS_RST;
      pad_en_q   <= PAD_EN_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_CENTER_X:   center_x_q <= pwdata[CFG_W-1:0];
        REG_RADIUS_X:   radius_x_q <= pwdata[CFG_W-1:0];
        REG_RADIUS_Y:   radius_y_q <= pwdata[CFG_W-1:0];
        REG_PAD_ENABLE: pad_en_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CENTER_X:   prdata = APB_DW'(center_x_q);
      REG_RADIUS_X:   prdata = APB_DW'(radius_x_q);
      REG_RADIUS_Y:   prdata = APB_DW'(radius_y_q);
      REG_PAD_ENABLE: prdata = APB_DW'(pad_en_q);
      default:        prdata = '0;
    endcase
  end

  // pad state
  pad_flags_t   flags;
  logic [C-1:0] anchor  [2][2];
  logic [C-1:0] current [2][2];
  logic         take;

  assign take = in_valid_i & in_ready_o;

  dtvj_pad_tracker #(.C(C)) u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .func_i       (func_i),
    .touch_x_i    (touch_x_i),
    .touch_y_i    (touch_y_i),
    .last_i       (last_in_event_i),
    .center_x_i   (center_x_q),
    .pad_enable_i (pad_en_q),
    .flags_o      (flags),
    .anchor_o     (anchor),
    .current_o    (current)
  );

  // axis sequencer
  state_e     state_q;
  logic [1:0] k_q;
  logic       neg_q;
  logic [AXIS_W-1:0] axis_q [4];
  logic [KNOB_W-1:0] knob_q [2];

  logic              pad_sel, ax_sel;
  logic [C-1:0]      cur_sel, anc_sel;
  logic [CFG_W-1:0]  rr_raw;
  logic [DW-1:0]     rr;
  logic signed [DW:0] d, rr_s, clip;
  logic [DW-1:0]     mag;
  logic signed [SW-1:0] knob_sum;

  logic              div_start, div_busy, div_done;
  logic [F:0]        quot;
  logic [AXIS_W:0]   v;
  logic [AXIS_W-1:0] axis_d;

  always_comb begin
    pad_sel = k_q[1];
    ax_sel  = k_q[0];
    cur_sel = current[pad_sel][ax_sel];
    anc_sel = anchor[pad_sel][ax_sel];
    rr_raw  = ax_sel ? radius_y_q : radius_x_q;
    rr      = (rr_raw == '0) ? DW'(1) : DW'(rr_raw);
    rr_s    = $signed({1'b0, rr});
    d       = $signed({1'b0, DW'(cur_sel)}) - $signed({1'b0, DW'(anc_sel)});
    if (d > rr_s) begin
      clip = rr_s;
    end else if (d < -rr_s) begin
      clip = -rr_s;
    end else begin
      clip = d;
    end
    mag      = clip[DW] ? DW'(-clip) : DW'(clip);
    knob_sum = $signed(SW'(anc_sel)) + SW'(clip);
  end

  assign div_start = (state_q == S_LOAD);

  dtvj_serdiv #(.W(DW), .F(F)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag),
    .divisor_i  (rr),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // full scale is 2^15, which saturates on the positive side
  always_comb begin
    v = (AXIS_W + 1)'(quot) << (AXIS_W - 1 - F);
    if (neg_q) begin
      axis_d = AXIS_W'(-v);
    end else begin
      axis_d = v[AXIS_W-1] ? AxisMax : v[AXIS_W-1:0];
    end
  end

  // output register
  logic              out_valid_q;
  logic              out_load;
  logic [AXIS_W-1:0] out_axis_q [4];
  logic [KNOB_W-1:0] out_knob_q [2];
  pad_flags_t        out_flags_q;

  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_flags_q <= '0;
      for (int i = 0; i < 4; i++) begin
        axis_q[i]     <= '0;
        out_axis_q[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        knob_q[i]     <= '0;
        out_knob_q[i] <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            k_q     <= '0;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          neg_q <= clip[DW];
          if (!pad_sel) begin
            knob_q[ax_sel] <= knob_sum[KNOB_W-1:0];
          end
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            axis_q[k_q] <= axis_d;
            if (k_q == 2'd3) begin
              state_q <= S_DONE;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= S_LOAD;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_q   <= 1'b1;
            out_flags_q   <= flags;
            out_axis_q[0] <= flags.left_valid  ? axis_q[0] : '0;
            out_axis_q[1] <= flags.left_valid  ? axis_q[1] : '0;
            out_axis_q[2] <= flags.right_valid ? axis_q[2] : '0;
            out_axis_q[3] <= flags.right_valid ? axis_q[3] : '0;
            out_knob_q[0] <= flags.left_valid  ? knob_q[0] : '0;
            out_knob_q[1] <= flags.left_valid  ? knob_q[1] : '0;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_axis_x_o  = out_axis_q[0];
  assign left_axis_y_o  = out_axis_q[1];
  assign right_axis_x_o = out_axis_q[2];
  assign right_axis_y_o = out_axis_q[3];
  assign left_active_o  = out_flags_q.left_valid;
  assign right_active_o = out_flags_q.right_valid;
  assign knob_x_o       = out_knob_q[0];
  assign knob_y_o       = out_knob_q[1];

  `DTVJ_ASSERT(a_done_in_div, clk_i, rst_ni, div_done |-> state_q == S_DIV, "stray done")
  `DTVJ_ASSERT(a_busy_in_div, clk_i, rst_ni, div_busy |-> state_q == S_DIV, "stray busy")
  `DTVJ_ASSERT(a_accept_loads, clk_i, rst_ni, take |=> state_q == S_LOAD && k_q == '0, "no load")

endmodule

### bench/tb_dual_touch_virtual_joystick_unit.sv
// ----------------------------------------------------------------------------
// tb_dual_touch_virtual_joystick_unit
// Self-checking bench for the two-pad virtual joystick. Touch words go in on
// the valid/ready input channel while an in-bench model of the pads predicts
// every stick report; each report taken from the output channel is compared
// field by field. A directed run over coordinate extremes, event endings,
// release-all, the unused code and the disabled pad comes first, then random
// touch events under several centre/radius/enable settings, with random
// stalls on both sides.
// ----------------------------------------------------------------------------
module tb_dual_touch_virtual_joystick_unit;
  import dtvj_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned COORD_MAX = (1 << TOUCH_W) - 1;

  typedef struct packed {
    logic [1:0]         func;
    logic [TOUCH_W-1:0] x;
    logic [TOUCH_W-1:0] y;
    logic               last;
  } touch_word_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] lx;
    logic signed [AXIS_W-1:0] ly;
    logic signed [AXIS_W-1:0] rx;
    logic signed [AXIS_W-1:0] ry;
    logic                     la;
    logic                     ra;
    logic signed [KNOB_W-1:0] kx;
    logic signed [KNOB_W-1:0] ky;
  } stick_report_t;

  typedef struct {
    logic               valid;
    logic               seen;
    logic [TOUCH_W-1:0] ax;
    logic [TOUCH_W-1:0] ay;
    logic [TOUCH_W-1:0] cx;
    logic [TOUCH_W-1:0] cy;
  } pad_state_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_AW-1:0]        paddr = '0;
  logic [APB_DW-1:0]        pwdata = '0;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               func_i = '0;
  logic [TOUCH_W-1:0]       touch_x_i = '0;
  logic [TOUCH_W-1:0]       touch_y_i = '0;
  logic                     last_in_event_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [AXIS_W-1:0] left_axis_x_o;
  logic signed [AXIS_W-1:0] left_axis_y_o;
  logic signed [AXIS_W-1:0] right_axis_x_o;
  logic signed [AXIS_W-1:0] right_axis_y_o;
  logic                     left_active_o;
  logic                     right_active_o;
  logic signed [KNOB_W-1:0] knob_x_o;
  logic signed [KNOB_W-1:0] knob_y_o;

  dual_touch_virtual_joystick_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .touch_x_i      (touch_x_i),
    .touch_y_i      (touch_y_i),
    .last_in_event_i(last_in_event_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_axis_x_o  (left_axis_x_o),
    .left_axis_y_o  (left_axis_y_o),
    .right_axis_x_o (right_axis_x_o),
    .right_axis_y_o (right_axis_y_o),
    .left_active_o  (left_active_o),
    .right_active_o (right_active_o),
    .knob_x_o       (knob_x_o),
    .knob_y_o       (knob_y_o)
  );

  always #1 clk_i = ~clk_i;

  // register shadows and pad model
  logic [CFG_W-1:0] cfg_center = CENTER_X_RST;
  logic [CFG_W-1:0] cfg_rad_x  = RADIUS_RST;
  logic [CFG_W-1:0] cfg_rad_y  = RADIUS_RST;
  logic             cfg_pad_en = PAD_EN_RST;
  pad_state_t       left_pad   = '{1'b0, 1'b0, '0, '0, '0, '0};
  pad_state_t       right_pad  = '{1'b0, 1'b0, '0, '0, '0, '0};

  touch_word_t   pending_words[$];
  stick_report_t expected_reports[$];

  int  in_idle_pct = 12;
  int  out_idle_pct = 12;
  bit  word_in_flight = 1'b0;
  int  mismatches = 0;
  int  words_accepted = 0;
  int  reports_checked = 0;
  int  words_planned = 0;
  int  settings_used = 1;
  int  lhx = 0, lhy = 0, rhx = 0, rhy = 0;

  function automatic int clipped(logic [TOUCH_W-1:0] cur, logic [TOUCH_W-1:0] anc,
                                 logic [CFG_W-1:0] r);
    int d;
    int rr;
    d  = int'(cur) - int'(anc);
    rr = (r == '0) ? 1 : int'(r);
    if (d > rr) d = rr;
    if (d < -rr) d = -rr;
    return d;
  endfunction

  function automatic logic signed [AXIS_W-1:0] deflection(logic [TOUCH_W-1:0] cur,
                                                          logic [TOUCH_W-1:0] anc,
                                                          logic [CFG_W-1:0] r);
    int          c;
    int unsigned rr;
    int unsigned mag;
    int unsigned v;
    c   = clipped(cur, anc, r);
    rr  = (r == '0) ? 1 : int'(r);
    mag = (c < 0) ? -c : c;
    v   = ((mag << AXIS_FRAC_BITS_DEF) / rr) << (15 - AXIS_FRAC_BITS_DEF);
    if (c >= 0) return (v > 32767) ? AXIS_W'(32767) : AXIS_W'(v);
    return AXIS_W'(32'h10000 - v);
  endfunction

  function automatic pad_state_t claim_point(pad_state_t p, logic [TOUCH_W-1:0] x,
                                             logic [TOUCH_W-1:0] y);
    if (p.seen) return p;
    p.seen = 1'b1;
    if (!p.valid) begin
      if (cfg_pad_en) begin
        p.ax = x; p.ay = y;
        p.cx = x; p.cy = y;
        p.valid = 1'b1;
      end
    end else begin
      p.cx = x; p.cy = y;
    end
    return p;
  endfunction

  function automatic void close_event();
    if (!left_pad.seen) left_pad.valid = 1'b0;
    if (!right_pad.seen) right_pad.valid = 1'b0;
    left_pad.seen  = 1'b0;
    right_pad.seen = 1'b0;
  endfunction

  task automatic predict_report(touch_word_t w);
    stick_report_t r;
    if (w.func == FUNC_POINT) begin
      if (w.x < cfg_center) left_pad = claim_point(left_pad, w.x, w.y);
      else right_pad = claim_point(right_pad, w.x, w.y);
      if (w.last) close_event();
    end else if (w.func == FUNC_EMPTY) begin
      close_event();
    end else if (w.func == FUNC_RELEASE) begin
      left_pad.valid  = 1'b0;
      right_pad.valid = 1'b0;
      left_pad.seen   = 1'b0;
      right_pad.seen  = 1'b0;
    end
    r = '0;
    if (left_pad.valid) begin
      r.lx = deflection(left_pad.cx, left_pad.ax, cfg_rad_x);
      r.ly = deflection(left_pad.cy, left_pad.ay, cfg_rad_y);
      r.kx = KNOB_W'(int'(left_pad.ax) + clipped(left_pad.cx, left_pad.ax, cfg_rad_x));
      r.ky = KNOB_W'(int'(left_pad.ay) + clipped(left_pad.cy, left_pad.ay, cfg_rad_y));
    end
    if (right_pad.valid) begin
      r.rx = deflection(right_pad.cx, right_pad.ax, cfg_rad_x);
      r.ry = deflection(right_pad.cy, right_pad.ay, cfg_rad_y);
    end
    r.la = left_pad.valid;
    r.ra = right_pad.valid;
    expected_reports.push_back(r);
  endtask

  // input side
  always @(posedge clk_i) begin : drive_touch
    touch_word_t held;
    logic        next_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      next_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        predict_report(held);
        words_accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid && pending_words.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
        held = pending_words.pop_front();
        func_i          <= held.func;
        touch_x_i       <= held.x;
        touch_y_i       <= held.y;
        last_in_event_i <= held.last;
        next_valid = 1'b1;
      end
      word_in_flight = next_valid;
      in_valid_i <= next_valid;
    end
  end

  task automatic check_field(string name, logic signed [AXIS_W-1:0] want,
                             logic signed [AXIS_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // output side
  always @(posedge clk_i) begin : watch_reports
    stick_report_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          $display("%0t ns: report word with none expected", $time);
        end else begin
          want = expected_reports.pop_front();
          check_field("left_axis_x", want.lx, left_axis_x_o);
          check_field("left_axis_y", want.ly, left_axis_y_o);
          check_field("right_axis_x", want.rx, right_axis_x_o);
          check_field("right_axis_y", want.ry, right_axis_y_o);
          check_field("left_active", want.la, left_active_o);
          check_field("right_active", want.ra, right_active_o);
          check_field("knob_x", want.kx, knob_x_o);
          check_field("knob_y", want.ky, knob_y_o);
          reports_checked++;
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  task automatic apb_write(reg_idx_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CENTER_X:   cfg_center = val;
      REG_RADIUS_X:   cfg_rad_x  = val;
      REG_RADIUS_Y:   cfg_rad_y  = val;
      REG_PAD_ENABLE: cfg_pad_en = val[0];
      default: ;
    endcase
  endtask

  task automatic write_settings(int c, int rx, int ry, int en);
    apb_write(REG_CENTER_X, CFG_W'(c));
    apb_write(REG_RADIUS_X, CFG_W'(rx));
    apb_write(REG_RADIUS_Y, CFG_W'(ry));
    apb_write(REG_PAD_ENABLE, CFG_W'(en));
    settings_used++;
  endtask

  task automatic push_word(logic [1:0] f, int x, int y, bit last);
    pending_words.push_back('{f, TOUCH_W'(x), TOUCH_W'(y), last});
    if (f != FUNC_UNUSED) words_planned++;
  endtask

  task automatic wait_all_reported();
    while (pending_words.size() != 0 || word_in_flight || expected_reports.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic int near(int base, int span);
    int v;
    v = base + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > int'(COORD_MAX)) v = COORD_MAX;
    return v;
  endfunction

  task automatic gen_random_event();
    int roll, ending, n, k, x, y, sx, sy;
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      push_word(FUNC_RELEASE, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                $urandom_range(0, 1));
      return;
    end
    if (roll < 7) begin
      push_word(FUNC_UNUSED, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                $urandom_range(0, 1));
      return;
    end
    if (roll < 10) begin
      push_word(FUNC_EMPTY, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                $urandom_range(0, 1));
      return;
    end
    if (cfg_center != 0 && ($urandom_range(0, 99) < 20 || lhx >= int'(cfg_center))) begin
      lhx = $urandom_range(0, int'(cfg_center) - 1);
      lhy = $urandom_range(0, COORD_MAX);
    end
    if ($urandom_range(0, 99) < 20 || rhx < int'(cfg_center)) begin
      rhx = $urandom_range(int'(cfg_center), COORD_MAX);
      rhy = $urandom_range(0, COORD_MAX);
    end
    sx = 2 * int'(cfg_rad_x) + 1;
    sy = 2 * int'(cfg_rad_y) + 1;
    if (sx > int'(COORD_MAX)) sx = COORD_MAX;
    if (sy > int'(COORD_MAX)) sy = COORD_MAX;
    n = $urandom_range(1, 4);
    ending = $urandom_range(0, 99);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 15) begin
        x = $urandom_range(0, COORD_MAX);
        y = $urandom_range(0, COORD_MAX);
      end else if (cfg_center != 0 && $urandom_range(0, 1) == 0) begin
        x = near(lhx, sx);
        y = near(lhy, sy);
      end else begin
        x = near(rhx, sx);
        y = near(rhy, sy);
      end
      push_word(FUNC_POINT, x, y, (k == n - 1) && (ending < 75));
    end
    // some events end on an empty word, a few are left open
    if (ending >= 75 && ending < 92) push_word(FUNC_EMPTY, 0, 0, 1'b0);
  endtask

  initial begin : stimulus
    int p, start, c, rx, ry, en, roll;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: centre 540, radii 400
    push_word(FUNC_POINT, 0, 0, 1'b0);
    push_word(FUNC_POINT, 4095, 4095, 1'b1);
    push_word(FUNC_POINT, 400, 0, 1'b0);
    push_word(FUNC_POINT, 4095, 0, 1'b1);
    push_word(FUNC_POINT, 0, 4095, 1'b1);
    push_word(FUNC_POINT, 539, 2048, 1'b0);
    push_word(FUNC_POINT, 100, 100, 1'b0);
    push_word(FUNC_POINT, 540, 0, 1'b1);
    push_word(FUNC_EMPTY, 0, 0, 1'b0);
    push_word(FUNC_POINT, 2730, 1365, 1'b0);
    push_word(FUNC_UNUSED, 4095, 4095, 1'b1);
    push_word(FUNC_RELEASE, 4095, 4095, 1'b1);
    push_word(FUNC_POINT, 1365, 2730, 1'b1);
    wait_all_reported();

    // centre at zero, zero radius behaves as one
    write_settings(0, 0, 4095, 1);
    push_word(FUNC_POINT, 0, 0, 1'b1);
    push_word(FUNC_POINT, 4095, 4095, 1'b1);
    push_word(FUNC_RELEASE, 0, 0, 1'b0);
    wait_all_reported();

    write_settings(4095, 1, 1, 1);
    push_word(FUNC_POINT, 4094, 10, 1'b1);
    push_word(FUNC_POINT, 4093, 12, 1'b1);
    wait_all_reported();

    // pads disabled: the active left pad keeps tracking, idle pads stay idle
    apb_write(REG_PAD_ENABLE, '0);
    push_word(FUNC_POINT, 4000, 20, 1'b0);
    push_word(FUNC_POINT, 4095, 0, 1'b1);
    push_word(FUNC_EMPTY, 0, 0, 1'b0);
    push_word(FUNC_POINT, 5, 5, 1'b1);
    wait_all_reported();

    for (p = 0; p < 6; p++) begin
      in_idle_pct  = (p == 3) ? 0 : 12;
      out_idle_pct = (p == 3) ? 0 : 12;
      roll = $urandom_range(0, 99);
      if (roll < 10) c = 0;
      else if (roll < 20) c = COORD_MAX;
      else c = $urandom_range(200, 3900);
      roll = $urandom_range(0, 99);
      rx = (roll < 70) ? $urandom_range(20, 800) :
           (roll < 85) ? $urandom_range(1, 4) : $urandom_range(2000, 4095);
      roll = $urandom_range(0, 99);
      ry = (roll < 70) ? $urandom_range(20, 800) :
           (roll < 85) ? $urandom_range(0, 4) : $urandom_range(2000, 4095);
      en = ($urandom_range(0, 99) < 80) ? 1 : 0;
      write_settings(c, rx, ry, en);
      start = words_planned;
      while (words_planned - start < 140) gen_random_event();
      wait_all_reported();
    end

    in_idle_pct  = 12;
    out_idle_pct = 12;
    repeat (80) @(posedge clk_i);
    if (expected_reports.size() != 0) begin
      mismatches++;
      $display("%0t ns: %0d reports never arrived", $time, expected_reports.size());
    end
    $display("Ran %0d touch words under %0d register settings; %0d reports checked.",
             words_accepted, settings_used, reports_checked);
    $display("Covered point, empty, release and unused words, pad disable and radius extremes.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
